[hdl/fsw_pkg.sv]
// package for the fourier series waveform evaluator
// holds operation codes, sequencer states and the cordic arctangent table
`timescale 1ns / 1ps
`default_nettype none
package fsw_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_HEADER = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_RD_A0,
    ST_A0,
    ST_PHASE,
    ST_ROT,
    ST_MUL_C,
    ST_MUL_S,
    ST_ADD,
    ST_SAT,
    ST_OUT
  } state_e;

  localparam logic signed [63:0] CordicStart = 64'sd652032874;
  localparam logic signed [63:0] P48Max = 64'sd140737488355327;
  localparam logic signed [63:0] P48Min = -64'sd140737488355328;

  function automatic logic [29:0] atan_turn(input logic [4:0] k);
    logic [29:0] r;
    case (k)
      5'd0: r = 30'd536870912;
      5'd1: r = 30'd316933406;
      5'd2: r = 30'd167458907;
      5'd3: r = 30'd85004756;
      5'd4: r = 30'd42667331;
      5'd5: r = 30'd21354465;
      5'd6: r = 30'd10679838;
      5'd7: r = 30'd5340245;
      5'd8: r = 30'd2670163;
      5'd9: r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/fsw_ram.sv]
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module fsw_ram #(
  parameter int Width = 32,
  parameter int Depth = 272
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/fsw_cordic.sv]
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on fsw_pkg for the arctangent table
`timescale 1ns / 1ps
`default_nettype none
module fsw_cordic
  import fsw_pkg::*;
#(
  parameter int CordicSteps = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        phase_i,
  output logic                    done_o,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [4:0] k_q, k_d;
  logic busy_q, busy_d, flip_q, flip_d;
  logic signed [33:0] zin, dx, dy, at;

  always_comb begin
    zin = 34'(signed'(phase_i));
    x_d = x_q; y_d = y_q; z_d = z_q; k_d = k_q;
    busy_d = busy_q; flip_d = flip_q;
    dx = y_q >>> k_q;
    dy = x_q >>> k_q;
    at = 34'(atan_turn(k_q));
    if (start_i) begin
      x_d = 34'(CordicStart);
      y_d = '0;
      k_d = '0;
      busy_d = 1'b1;
      flip_d = 1'b0;
      z_d = zin;
      if (zin > 34'sd1073741824) begin
        z_d = zin - 34'sd2147483648; flip_d = 1'b1;
      end else if (zin < -34'sd1073741824) begin
        z_d = zin + 34'sd2147483648; flip_d = 1'b1;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
      end else begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
      end
      k_d = k_q + 5'd1;
      if (k_q == 5'(CordicSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q <= '0;
    end else begin
      busy_q <= busy_d;
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; flip_q <= flip_d;
  end

  assign done_o = busy_q && (k_q == 5'(CordicSteps - 1));
  // results valid the cycle after done_o
  assign cos_o = flip_q ? -x_q : x_q;
  assign sin_o = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

[hdl/fourier_series_waveform_eval.sv]
// top level of the fourier series waveform evaluator
// depends on fsw_pkg, fsw_ram and fsw_cordic
//
// channel  dir  tdata fields (low bit up)                        tuser
// s_axis   in   boundary, mode_index, coef_cos, coef_sin,         operation
//               mode_count, omega_rate, sample_time
// m_axis   out  pressure                                          saturated
//
// load and header beats leave the evaluator idle; an evaluate steps each mode
// through the one iterative cordic and the single shared 34x34 multiplier.
// no clearing pass after reset.
// the result waits in an output register; s_axis_tready is low while busy.
`timescale 1ns / 1ps
`default_nettype none
module fourier_series_waveform_eval
  import fsw_pkg::*;
#(
  parameter int NUM_BOUNDARIES = 16,
  parameter int MAX_MODES = 16,
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // boundary[3:0], mode_index[8:4], coef_cos[40:9], coef_sin[72:41],
  // mode_count[77:73], omega_rate[109:78], sample_time[141:110]
  input  wire logic [143:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pressure[47:0]
  output logic [47:0]       m_axis_tdata,
  // saturated[0]
  output logic              m_axis_tuser
);
  localparam int Slots = MAX_MODES + 1;
  localparam int Depth = NUM_BOUNDARIES * Slots;
  localparam int AW = $clog2(Depth);
  localparam int BW = (NUM_BOUNDARIES > 1) ? $clog2(NUM_BOUNDARIES) : 1;
  localparam int MW = $clog2(MAX_MODES + 1);

  logic [3:0]  in_bnd;
  logic [4:0]  in_mode, in_cnt;
  logic [31:0] in_cos, in_sin, in_rate, in_time;
  op_e         in_op;
  assign in_bnd  = s_axis_tdata[3:0];
  assign in_mode = s_axis_tdata[8:4];
  assign in_cos  = s_axis_tdata[40:9];
  assign in_sin  = s_axis_tdata[72:41];
  assign in_cnt  = s_axis_tdata[77:73];
  assign in_rate = s_axis_tdata[109:78];
  assign in_time = s_axis_tdata[141:110];
  assign in_op   = op_e'(s_axis_tuser);

  state_e state_q, state_d;
  logic [MW-1:0] cnt_q [NUM_BOUNDARIES];
  logic [31:0]   rate_q [NUM_BOUNDARIES];
  logic [AW-1:0] base_q, base_d;
  logic [MW-1:0] n_q, n_d, i_q, i_d;
  logic          bok_q, bok_d;
  logic [31:0]   time_q, time_d, rsel_q, rsel_d;
  logic [63:0]   p_q, p_d, ip_q, ip_d;
  logic signed [63:0] acc_q, acc_d, t_q, t_d;
  logic [47:0]   pres_q, pres_d;
  logic          sat_q, sat_d, ovalid_q, ovalid_d;

  logic acc_in;
  assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  logic bnd_in_range;
  assign bnd_in_range = 32'(in_bnd) < NUM_BOUNDARIES;
  logic [BW-1:0] bidx;
  assign bidx = BW'(in_bnd);

  // coefficient stores
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] cos_rd, sin_rd;
  assign we = acc_in && in_op == OP_LOAD && bnd_in_range && 32'(in_mode) <= MAX_MODES;
  assign waddr = AW'(32'(in_bnd) * Slots + 32'(in_mode));
  assign raddr = base_q + AW'(i_q);

  fsw_ram #(.Width(32), .Depth(Depth)) u_cos_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_cos),
    .raddr_i(raddr), .rdata_o(cos_rd));
  fsw_ram #(.Width(32), .Depth(Depth)) u_sin_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(in_sin),
    .raddr_i(raddr), .rdata_o(sin_rd));

  // cordic
  logic cstart, cdone;
  logic signed [33:0] ccos, csin;
  fsw_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .phase_i(ip_q[39:8]),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin));

  // shared multiplier: 32x32 unsigned for the phase, 32x34 signed for terms
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  always_comb begin
    if (state_q == ST_PROD) begin
      ma = 34'(rsel_q); mb = 34'(time_q);
    end else if (state_q == ST_MUL_C) begin
      ma = 34'(signed'(cos_rd)); mb = ccos;
    end else begin
      ma = 34'(signed'(sin_rd)); mb = csin;
    end
    mp = ma * mb;
  end

  logic cdone_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cdone_q <= 1'b0;
    else         cdone_q <= cdone;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (acc_in && in_op == OP_EVAL) state_d = ST_PROD;
      ST_PROD:  state_d = ST_RD_A0;
      ST_RD_A0: state_d = ST_A0;
      ST_A0:    state_d = (n_q == '0 || !bok_q) ? ST_SAT : ST_PHASE;
      ST_PHASE: state_d = ST_ROT;
      ST_ROT:   if (cdone_q) state_d = ST_MUL_C;
      ST_MUL_C: state_d = ST_MUL_S;
      ST_MUL_S: state_d = ST_ADD;
      ST_ADD:   state_d = (i_q == n_q) ? ST_SAT : ST_PHASE;
      ST_SAT:   state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign cstart = (state_q == ST_PHASE);

  // datapath
  always_comb begin
    base_d = base_q; n_d = n_q; i_d = i_q; bok_d = bok_q;
    time_d = time_q; rsel_d = rsel_q; p_d = p_q; ip_d = ip_q;
    acc_d = acc_q; t_d = t_q; pres_d = pres_q; sat_d = sat_q;
    ovalid_d = ovalid_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in && in_op == OP_EVAL) begin
          bok_d = bnd_in_range;
          base_d = AW'(32'(in_bnd) * Slots);
          n_d = cnt_q[bidx];
          rsel_d = rate_q[bidx];
          time_d = in_time;
          i_d = '0;
        end
      end
      ST_PROD: begin
        p_d = 64'(mp[63:0]);
        ip_d = '0;
      end
      ST_A0: begin
        acc_d = bok_q ? 64'(signed'(cos_rd)) : '0;
        i_d = MW'(1);
        ip_d = p_q;
      end
      ST_MUL_C: t_d = 64'(mp);
      ST_MUL_S: t_d = t_q + 64'(mp);
      ST_ADD: begin
        acc_d = acc_q + ((t_q + 64'sd536870912) >>> 30);
        i_d = i_q + MW'(1);
        ip_d = ip_q + p_q;
      end
      ST_SAT: begin
        sat_d = 1'b0;
        pres_d = acc_q[47:0];
        if (acc_q > P48Max) begin
          pres_d = P48Max[47:0]; sat_d = 1'b1;
        end else if (acc_q < P48Min) begin
          pres_d = P48Min[47:0]; sat_d = 1'b1;
        end
      end
      ST_OUT: ovalid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovalid_q <= 1'b0;
      for (int b = 0; b < NUM_BOUNDARIES; b++) begin
        cnt_q[b] <= '0;
        rate_q[b] <= '0;
      end
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      if (acc_in && in_op == OP_HEADER && bnd_in_range) begin
        cnt_q[bidx] <= (32'(in_cnt) > MAX_MODES) ? MW'(MAX_MODES) : MW'(in_cnt);
        rate_q[bidx] <= in_rate;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d; n_q <= n_d; i_q <= i_d; bok_q <= bok_d;
    time_q <= time_d; rsel_q <= rsel_d; p_q <= p_d; ip_q <= ip_d;
    acc_q <= acc_d; t_q <= t_d; pres_q <= pres_d; sat_q <= sat_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = pres_q;
  assign m_axis_tuser  = sat_q;
endmodule
`default_nettype wire
